>>> design/hpt_pkg.sv
// ---------------------------------------------------------------------------
// hpt_pkg
// Shared widths, codes and helpers for the histogram percentile tree core.
// ---------------------------------------------------------------------------
package hpt_pkg;

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned SAMPLE_W  = 32;
   localparam int unsigned PCT_W     = 14;
   localparam int unsigned IDX_W     = 4;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned SUM_W     = 64;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RANK_W    = COUNT_W + PCT_W;

   localparam int unsigned PCT_FULL  = 10000;

   // request payload offsets
   localparam int unsigned REQ_SAMPLE_LSB = 0;
   localparam int unsigned REQ_PCT_LSB    = REQ_SAMPLE_LSB + SAMPLE_W;
   localparam int unsigned REQ_IDX_LSB    = REQ_PCT_LSB + PCT_W;
   localparam int unsigned REQ_BVAL_LSB   = REQ_IDX_LSB + IDX_W;
   localparam int unsigned REQ_BITS       = REQ_BVAL_LSB + SAMPLE_W;
   localparam int unsigned REQ_DATA_W     = ((REQ_BITS + 7) / 8) * 8;

   // response payload offsets
   localparam int unsigned RSP_PVAL_LSB  = 0;
   localparam int unsigned RSP_UNB_LSB   = RSP_PVAL_LSB + SAMPLE_W;
   localparam int unsigned RSP_TOTAL_LSB = RSP_UNB_LSB + 1;
   localparam int unsigned RSP_SUM_LSB   = RSP_TOTAL_LSB + COUNT_W;
   localparam int unsigned RSP_SQ_LSB    = RSP_SUM_LSB + SUM_W;
   localparam int unsigned RSP_BITS      = RSP_SQ_LSB + SUM_W;
   localparam int unsigned RSP_DATA_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD   = 2'd0,
      CMD_QUERY    = 2'd1,
      CMD_BOUNDARY = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == '1) ? v : v + COUNT_W'(1);
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

endpackage

>>> design/histogram_percentile_tree_core.sv
// ---------------------------------------------------------------------------
// histogram_percentile_tree_core
// Bucket histogram held as a counting segment tree, with running sums and a
// percentile search over one shared multiplier and a small sequencer.
// ---------------------------------------------------------------------------
// Sequencing per command, over the clog2(BUCKET_COUNT) levels of the tree:
//   record: one count read-modify-write per node on the root-to-leaf path
//   query: count read, scale by 10000, compare per level; rejected queries skip the descent
//   boundary write and unknown command: straight to the response
// One request at a time; the next is taken once the result sits in the output register.
// Synchronous reset, then a clear pass over all 2*BUCKET_COUNT-1 tree nodes with req_tready low.
module histogram_percentile_tree_core #(
   parameter int unsigned BUCKET_COUNT = 16,
   parameter int unsigned SAMPLE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample[31:0], percent[45:32], boundary_index[49:46],
   // boundary_value[81:50], zero pad
   input  logic [hpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [hpt_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // percentile_value[31:0], percentile_unbounded[32], total_count[64:33],
   // sum_of_samples[128:65], sum_of_squares[192:129], zero pad
   output logic [hpt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic [hpt_pkg::STATUS_W-1:0]     rsp_tuser
);
   import hpt_pkg::*;

   localparam int unsigned NODES  = 2 * BUCKET_COUNT - 1;
   localparam int unsigned LIMITS = BUCKET_COUNT - 1;
   localparam int unsigned NODE_W = $clog2(NODES);
   localparam int unsigned BKT_W  = $clog2(BUCKET_COUNT);
   localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(BUCKET_COUNT - 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_MUL   = 8'b0000_0100,
      S_READ  = 8'b0000_1000,
      S_MULC  = 8'b0001_0000,
      S_STEP  = 8'b0010_0000,
      S_LIMIT = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [NODE_W-1:0]         clr_ff, clr_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic [SAMPLE_WIDTH-1:0]   value_ff, value_in;
   logic [PCT_W-1:0]          pct_ff, pct_in;
   logic [NODE_W-1:0]         node_ff, node_in;
   logic [BKT_W-1:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic [SUM_W-1:0]          prod_ff, prod_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [COUNT_W-1:0]        total_ff, total_in;
   logic [SUM_W-1:0]          sum_ff, sum_in, sq_ff, sq_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [SAMPLE_W-1:0]       rsp_pval_ff, rsp_pval_in;
   logic                      rsp_unb_ff, rsp_unb_in;
   logic [COUNT_W-1:0]        rsp_total_ff, rsp_total_in;
   logic [SUM_W-1:0]          rsp_sum_ff, rsp_sum_in, rsp_sq_ff, rsp_sq_in;

   logic [COUNT_W-1:0]        cnt_mem [NODES];
   logic [COUNT_W-1:0]        cnt_rd_ff;
   logic                      cnt_we, cnt_re;
   logic [NODE_W-1:0]         cnt_wa, cnt_ra;
   logic [COUNT_W-1:0]        cnt_wd;

   logic [SAMPLE_WIDTH-1:0]   lim_mem [LIMITS];
   logic [SAMPLE_WIDTH-1:0]   lim_rd_ff;
   logic                      lim_we, lim_re;
   logic [BKT_W-1:0]          lim_wa, lim_ra;

   logic [BKT_W:0]            mid_sum;
   logic [BKT_W-1:0]          mid;
   logic [NODE_W-1:0]         node_left, node_right;
   logic [31:0]               mul_a, mul_b;
   logic [SUM_W-1:0]          mul_p;
   logic                      go_left;
   logic                      req_fire;
   logic [IDX_W-1:0]          req_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_idx    = req_tdata[REQ_IDX_LSB +: IDX_W];

   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[BKT_W:1];
   assign node_left  = node_ff + NODE_W'(1);
   assign node_right = node_ff + ((NODE_W'(mid) - NODE_W'(lo_ff) + NODE_W'(1)) << 1);

   // shared multiplier
   always_comb begin
      mul_a = 32'(value_ff);
      mul_b = 32'(value_ff);
      if (state_ff == S_MULC) begin
         mul_a = cnt_rd_ff;
         mul_b = 32'(PCT_FULL);
      end else if (cmd_ff == CMD_QUERY) begin
         mul_a = total_ff;
         mul_b = 32'(pct_ff);
      end
      mul_p = mul_a * mul_b;
   end

   assign go_left = (cmd_ff == CMD_QUERY) ? (prod_ff[RANK_W-1:0] >= rank_ff)
                                          : (lim_rd_ff > value_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      pct_in        = pct_ff;
      node_in       = node_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rank_in       = rank_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      total_in      = total_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pval_in   = rsp_pval_ff;
      rsp_unb_in    = rsp_unb_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_sq_in     = rsp_sq_ff;
      cnt_we        = 1'b0;
      cnt_wa        = node_ff;
      cnt_wd        = sat_inc(cnt_rd_ff);
      cnt_re        = 1'b0;
      cnt_ra        = (cmd_ff == CMD_QUERY) ? node_left : node_ff;
      lim_we        = 1'b0;
      lim_wa        = BKT_W'(req_idx);
      lim_re        = 1'b0;
      lim_ra        = mid;

      case (state_ff)
         S_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = clr_ff;
            cnt_wd = '0;
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_tuser;
               value_in  = req_tdata[REQ_SAMPLE_LSB +: SAMPLE_WIDTH];
               pct_in    = req_tdata[REQ_PCT_LSB +: PCT_W];
               node_in   = '0;
               lo_in     = '0;
               hi_in     = LAST_BKT;
               status_in = ST_OK;
               case (req_tuser)
                  CMD_RECORD, CMD_QUERY: begin
                     state_in = S_MUL;
                  end
                  CMD_BOUNDARY: begin
                     lim_we   = (32'(req_idx) < 32'(LIMITS));
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_READ;
            if (cmd_ff == CMD_QUERY) begin
               rank_in = mul_p[RANK_W-1:0];
               if (32'(pct_ff) > 32'(PCT_FULL)) begin
                  status_in = ST_RANGE;
                  state_in  = S_RESP;
               end else if (total_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_RESP;
               end
            end
         end
         S_READ: begin
            cnt_re   = 1'b1;
            lim_re   = (lo_ff != hi_ff) && (cmd_ff == CMD_RECORD);
            state_in = (cmd_ff == CMD_QUERY) ? S_MULC : S_STEP;
         end
         S_MULC: begin
            prod_in  = mul_p;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (cmd_ff == CMD_RECORD) begin
               cnt_we = 1'b1;
            end
            if (cmd_ff == CMD_RECORD && lo_ff == hi_ff) begin
               total_in = sat_inc(total_ff);
               sum_in   = sat_add(sum_ff, SUM_W'(value_ff));
               sq_in    = sat_add(sq_ff, prod_ff);
               state_in = S_RESP;
            end else begin
               if (go_left) begin
                  node_in = node_left;
                  hi_in   = mid;
               end else begin
                  node_in = node_right;
                  lo_in   = mid + BKT_W'(1);
                  if (cmd_ff == CMD_QUERY) begin
                     rank_in = rank_ff - prod_ff[RANK_W-1:0];
                  end
               end
               if (cmd_ff == CMD_QUERY && lo_in == hi_in) begin
                  state_in = S_LIMIT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_LIMIT: begin
            lim_ra   = lo_ff;
            lim_re   = (lo_ff != LAST_BKT);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pval_in   = '0;
               rsp_unb_in    = 1'b0;
               if (cmd_ff == CMD_QUERY && status_ff == ST_OK) begin
                  if (lo_ff == LAST_BKT) begin
                     rsp_unb_in = 1'b1;
                  end else begin
                     rsp_pval_in = SAMPLE_W'(lim_rd_ff);
                  end
               end
               rsp_total_in = total_ff;
               rsp_sum_in   = sum_ff;
               rsp_sq_in    = sq_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (lim_we) begin
         lim_mem[lim_wa] <= req_tdata[REQ_BVAL_LSB +: SAMPLE_WIDTH];
      end
      if (lim_re) begin
         lim_rd_ff <= lim_mem[lim_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cmd_ff       <= CMD_RECORD;
         lo_ff        <= '0;
         hi_ff        <= LAST_BKT;
         status_ff    <= ST_OK;
         total_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cmd_ff       <= cmd_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         status_ff    <= status_in;
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      pct_ff        <= pct_in;
      node_ff       <= node_in;
      rank_ff       <= rank_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pval_ff   <= rsp_pval_in;
      rsp_unb_ff    <= rsp_unb_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_sq_ff     <= rsp_sq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_sq_ff, rsp_sum_ff, rsp_total_ff,
                                    rsp_unb_ff, rsp_pval_ff});

   // sample count moves by at most one per cycle and never drops
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> ({1'b0, total_ff} == {1'b0, $past(total_ff)}) ||
                 ({1'b0, total_ff} == {1'b0, $past(total_ff)} + 33'd1))
      else $error("total count jumped");

   a_sum_mono: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (sum_ff >= $past(sum_ff)) && (sq_ff >= $past(sq_ff)))
      else $error("running sum decreased");

   a_range: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("descent range inverted");

endmodule
